[rtl/tbdg_pkg.sv]
// Shared types, constants and the sine table for the tone burst DDS generator.
// No dependencies.
package tbdg_pkg;

  localparam int unsigned FREQ_W    = 15;
  localparam int unsigned CODE_W    = 11;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned LED_W     = 2;
  localparam int unsigned ROM_DEPTH = 64;
  localparam int unsigned ROM_IDX_W = 6;

  localparam logic [CODE_W-1:0]  MIDSCALE        = 11'd1024;
  localparam logic [COUNT_W-1:0] BURST_LEN_RESET = 16'd22050;
  localparam logic [63:0]        SAMPLE_RATE     = 64'd44100;

  localparam logic [FREQ_W-1:0] FREQ_330  = 15'd330;
  localparam logic [FREQ_W-1:0] FREQ_660  = 15'd660;
  localparam logic [FREQ_W-1:0] FREQ_1000 = 15'd1000;

  localparam logic [LED_W-1:0] LED_OFF  = 2'd0;
  localparam logic [LED_W-1:0] LED_330  = 2'd1;
  localparam logic [LED_W-1:0] LED_1000 = 2'd2;
  localparam logic [LED_W-1:0] LED_660  = 2'd3;

  localparam logic [CODE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
    11'd1024, 11'd1122, 11'd1219, 11'd1314, 11'd1407, 11'd1495, 11'd1580, 11'd1658,
    11'd1731, 11'd1798, 11'd1855, 11'd1906, 11'd1948, 11'd1979, 11'd2001, 11'd2015,
    11'd2024, 11'd2015, 11'd2001, 11'd1979, 11'd1948, 11'd1906, 11'd1855, 11'd1798,
    11'd1731, 11'd1658, 11'd1580, 11'd1495, 11'd1407, 11'd1314, 11'd1219, 11'd1122,
    11'd1024, 11'd926,  11'd829,  11'd734,  11'd641,  11'd554,  11'd469,  11'd392,
    11'd314,  11'd247,  11'd190,  11'd139,  11'd93,   11'd58,   11'd27,   11'd5,
    11'd0,    11'd5,    11'd27,   11'd58,   11'd93,   11'd139,  11'd190,  11'd247,
    11'd314,  11'd392,  11'd469,  11'd554,  11'd641,  11'd734,  11'd829,  11'd926
  };

  typedef struct packed {
    logic              load;
    logic [FREQ_W-1:0] new_freq;
    logic [FREQ_W-1:0] enc_freq;
  } item_t;

  function automatic logic [LED_W-1:0] led_for(input logic [FREQ_W-1:0] f);
    logic [LED_W-1:0] led;
    priority if (f == FREQ_330) begin
      led = LED_330;
    end else if (f == FREQ_1000) begin
      led = LED_1000;
    end else if (f == FREQ_660) begin
      led = LED_660;
    end else begin
      led = LED_OFF;
    end
    return led;
  endfunction

endpackage

[rtl/tbdg_step_calc.sv]
// Frequency to phase increment: step = (f * floor(2^(PW+16)/fs)) >> 16.
// Depends on tbdg_pkg.
module tbdg_step_calc #(
  parameter int unsigned PHASE_WIDTH = 16
) (
  input  logic [tbdg_pkg::FREQ_W-1:0] freq_i,
  output logic [PHASE_WIDTH-1:0]      step_o
);
  import tbdg_pkg::*;

  localparam int unsigned MULT_W    = PHASE_WIDTH + 1;
  localparam int unsigned PROD_W    = FREQ_W + MULT_W;
  localparam logic [63:0] MULT_FULL = (64'd1 << (PHASE_WIDTH + 16)) / SAMPLE_RATE;
  localparam logic [MULT_W-1:0] STEP_MULT = MULT_FULL[MULT_W-1:0];

  logic [PROD_W-1:0] prod;

  assign prod   = {{MULT_W{1'b0}}, freq_i} * {{FREQ_W{1'b0}}, STEP_MULT};
  assign step_o = prod[PHASE_WIDTH+15:16];

endmodule

[rtl/tbdg_core.sv]
// Burst state (phase accumulator, tick counter, frequency) and the result register.
// Depends on tbdg_pkg.
module tbdg_core #(
  parameter int unsigned PHASE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tbdg_pkg::item_t              item_i,
  input  logic [PHASE_WIDTH-1:0]       new_step_i,
  input  logic [PHASE_WIDTH-1:0]       enc_step_i,
  input  logic [tbdg_pkg::COUNT_W-1:0] burst_len_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         dac_write_o,
  output logic [tbdg_pkg::CODE_W-1:0]  dac_code_o,
  output logic [tbdg_pkg::LED_W-1:0]   led_bits_o
);
  import tbdg_pkg::*;

  logic                   adv;
  logic                   playing_q, playing_d;
  logic [COUNT_W-1:0]     tick_q, tick_d;
  logic [PHASE_WIDTH-1:0] phase_q, phase_d;
  logic [FREQ_W-1:0]      tone_q, tone_d;
  logic [PHASE_WIDTH-1:0] step_q, step_d;
  logic [LED_W-1:0]       led_q, led_d;
  logic                   out_valid_q;
  logic                   wr_q, wr_d;
  logic [CODE_W-1:0]      code_q, code_d;
  logic [FREQ_W-1:0]      freq_eff;
  logic [PHASE_WIDTH-1:0] step_eff;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign adv        = in_valid_i && in_ready_o;

  // step register always tracks step_for(tone), so no recompute on burst start
  assign freq_eff = item_i.load ? item_i.new_freq : tone_q;
  assign step_eff = item_i.load ? new_step_i : step_q;

  always_comb begin
    playing_d = playing_q;
    tick_d    = tick_q;
    phase_d   = phase_q;
    tone_d    = freq_eff;
    step_d    = step_eff;
    led_d     = led_q;
    wr_d      = 1'b0;
    code_d    = '0;
    if (playing_q) begin
      if (tick_q < burst_len_i) begin
        wr_d    = 1'b1;
        code_d  = SINE_ROM[phase_q[PHASE_WIDTH-1 -: ROM_IDX_W]];
        phase_d = phase_q + step_eff;
        tick_d  = tick_q + 16'd1;
      end else begin
        playing_d = 1'b0;
        wr_d      = 1'b1;
        code_d    = MIDSCALE;
        led_d     = LED_OFF;
        tone_d    = item_i.enc_freq;
        step_d    = enc_step_i;
        tick_d    = '0;
        phase_d   = '0;
      end
    end else if (freq_eff != '0) begin
      playing_d = 1'b1;
      tick_d    = '0;
      phase_d   = '0;
      led_d     = led_for(freq_eff);
    end else begin
      led_d  = LED_OFF;
      wr_d   = 1'b1;
      code_d = MIDSCALE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q   <= 1'b0;
      tick_q      <= '0;
      phase_q     <= '0;
      tone_q      <= '0;
      step_q      <= '0;
      led_q       <= LED_OFF;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        playing_q <= playing_d;
        tick_q    <= tick_d;
        phase_q   <= phase_d;
        tone_q    <= tone_d;
        step_q    <= step_d;
        led_q     <= led_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_q   <= wr_d;
      code_q <= code_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_write_o = wr_q;
  assign dac_code_o  = code_q;
  assign led_bits_o  = led_q;

`ifndef NO_ASSERTIONS
  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> (tick_q == '0 && phase_q == '0))
    else $error("idle with nonzero tick count or phase");

  a_led_needs_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (led_q != LED_OFF) |-> playing_q)
    else $error("LED bits set outside a burst");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !wr_q) |-> (code_q == '0))
    else $error("code nonzero on a tick without a converter write");

  a_start_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !wr_q) |-> (playing_q && tick_q == '0))
    else $error("silent tick did not start a burst");
`endif

endmodule

[rtl/tone_burst_dds_generator.sv]
// Top level of the tone burst DDS generator: input register, step multipliers,
// burst_length register. Depends on tbdg_pkg, tbdg_step_calc, tbdg_core.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------------
//  in       | in_valid_i / in_ready_o     | load_frequency_i, new_frequency_i,
//           |                             | encoder_frequency_i
//  out      | out_valid_o / out_ready_i   | dac_write_o, dac_code_o, led_bits_o
//  cfg      | cfg_we_i (no wait)          | cfg_wdata_i -> burst_length
//
// One transaction in and one out per cycle sustained while out_ready_i is high; a
// result passes through the input register, then the result register.
// Phase steps are multiplied on the way into the input register, so the state
// update is only a table lookup, an add and a compare.
// Reset: burst idle, burst state zero, burst_length 22050.
// A stall on the output backs up through the result and input registers.
module tone_burst_dds_generator #(
  parameter int unsigned PHASE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tbdg_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         load_frequency_i,
  input  logic [tbdg_pkg::FREQ_W-1:0]  new_frequency_i,
  input  logic [tbdg_pkg::FREQ_W-1:0]  encoder_frequency_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         dac_write_o,
  output logic [tbdg_pkg::CODE_W-1:0]  dac_code_o,
  output logic [tbdg_pkg::LED_W-1:0]   led_bits_o
);
  import tbdg_pkg::*;

  logic [COUNT_W-1:0]     burst_len_q;
  logic                   s1_valid_q;
  item_t                  s1_item_q;
  logic [PHASE_WIDTH-1:0] s1_new_step_q, s1_enc_step_q;
  logic [PHASE_WIDTH-1:0] new_step, enc_step;
  logic                   core_ready;
  logic                   take;

  tbdg_step_calc #(.PHASE_WIDTH(PHASE_WIDTH)) u_new_step (
    .freq_i (new_frequency_i),
    .step_o (new_step)
  );

  tbdg_step_calc #(.PHASE_WIDTH(PHASE_WIDTH)) u_enc_step (
    .freq_i (encoder_frequency_i),
    .step_o (enc_step)
  );

  assign in_ready_o = !s1_valid_q || core_ready;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_len_q <= BURST_LEN_RESET;
      s1_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        burst_len_q <= cfg_wdata_i;
      end
      if (take) begin
        s1_valid_q <= 1'b1;
      end else if (core_ready) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_item_q.load     <= load_frequency_i;
      s1_item_q.new_freq <= new_frequency_i;
      s1_item_q.enc_freq <= encoder_frequency_i;
      s1_new_step_q      <= new_step;
      s1_enc_step_q      <= enc_step;
    end
  end

  tbdg_core #(.PHASE_WIDTH(PHASE_WIDTH)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (core_ready),
    .item_i      (s1_item_q),
    .new_step_i  (s1_new_step_q),
    .enc_step_i  (s1_enc_step_q),
    .burst_len_i (burst_len_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dac_write_o (dac_write_o),
    .dac_code_o  (dac_code_o),
    .led_bits_o  (led_bits_o)
  );

endmodule
